/* rtl/lis_pkg.sv */
// Shared types and constants for the longest increasing subsequence block.
// No dependencies; imported by lis_cell and longest_increasing_subsequence.
package lis_pkg;

   // Width and ceiling of the reported subsequence length.
   localparam int LENGTH_BITS = 9;
   localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = '1;

   // Control part of a beat as it travels down the cell chain.
   typedef struct packed {
      logic valid;   // a beat occupies this slot
      logic active;  // still looking for a free cell
      logic last;    // final element of the sequence
   } lis_ctl_type;

endpackage

/* rtl/lis_cell.sv */
// One cell of the subsequence chain: holds one stored element and its ending length.
// Depends on lis_pkg for the beat control struct.
module lis_cell #(
   parameter int VALUE_BITS = 32,
   parameter int LEN_BITS   = 9
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lis_pkg::lis_ctl_type          ctl_in,
   input  logic signed [VALUE_BITS-1:0]  key_in,
   input  logic [LEN_BITS-1:0]           len_in,
   input  logic [LEN_BITS-1:0]           best_in,
   output lis_pkg::lis_ctl_type          ctl_out,
   output logic signed [VALUE_BITS-1:0]  key_out,
   output logic [LEN_BITS-1:0]           len_out,
   output logic [LEN_BITS-1:0]           best_out
);
   import lis_pkg::*;

   logic                          occupied_ff, occupied_in;
   logic signed [VALUE_BITS-1:0]  value_ff, value_in;
   logic [LEN_BITS-1:0]           length_ff, length_in;
   lis_ctl_type                   ctl_ff, ctl_nx_in;
   logic signed [VALUE_BITS-1:0]  key_ff;
   logic [LEN_BITS-1:0]           len_ff, len_nx_in;
   logic [LEN_BITS-1:0]           best_ff, best_nx_in;
   logic [LEN_BITS-1:0]           grow;

   assign grow = length_ff + LEN_BITS'(1);

   always_comb begin
      occupied_in = occupied_ff;
      value_in    = value_ff;
      length_in   = length_ff;
      ctl_nx_in   = ctl_in;
      len_nx_in   = len_in;
      best_nx_in  = best_in;
      if (ctl_in.valid && ctl_in.active) begin
         if (occupied_ff) begin
            // Extend a subsequence that ends on a smaller stored element.
            if ((value_ff < key_in) && (grow > len_in)) begin
               len_nx_in = grow;
            end
            if (length_ff > best_in) begin
               best_nx_in = length_ff;
            end
         end else begin
            // First free cell: the length is final here.
            ctl_nx_in.active = 1'b0;
            if (!ctl_in.last) begin
               occupied_in = 1'b1;
               value_in    = key_in;
               length_in   = len_in;
            end
         end
      end
      // The closing beat empties every cell it passes for the next sequence.
      if (ctl_in.valid && ctl_in.last) begin
         occupied_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occupied_ff <= 1'b0;
         ctl_ff      <= '0;
      end else begin
         occupied_ff <= occupied_in;
         ctl_ff      <= ctl_nx_in;
      end
      value_ff  <= value_in;
      length_ff <= length_in;
      key_ff    <= key_in;
      len_ff    <= len_nx_in;
      best_ff   <= best_nx_in;
   end

   assign ctl_out  = ctl_ff;
   assign key_out  = key_ff;
   assign len_out  = len_ff;
   assign best_out = best_ff;

endmodule

/* rtl/longest_increasing_subsequence.sv */
// Streaming longest strictly increasing subsequence length over a chain of cells.
// Throughput: one beat per cycle while busy is low; busy is set by reset and clears once reset is released.
// Each beat walks the chain one cell per cycle, so the chain length sets the latency.
// Reset is synchronous and empties every cell; results cannot be stalled.
// Depends on lis_pkg and lis_cell.
module longest_increasing_subsequence #(
   parameter int MAX_ITEMS  = 256,
   parameter int VALUE_BITS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [VALUE_BITS-1:0]          req_value,
   input  logic                                  req_last_item,
   output logic                                  rsp_strobe,
   output logic [lis_pkg::LENGTH_BITS-1:0]       rsp_subsequence_length,
   output logic                                  rsp_overflow
);
   import lis_pkg::*;

   // Lengths run from 1 to MAX_ITEMS inside the chain.
   localparam int LEN_BITS  = $clog2(MAX_ITEMS + 1);
   localparam int WIDE_BITS = (LEN_BITS > LENGTH_BITS) ? LEN_BITS : LENGTH_BITS;

   // Slot i feeds cell i; slot MAX_ITEMS is the tail of the chain.
   lis_ctl_type                   chain_ctl  [MAX_ITEMS+1];
   logic signed [VALUE_BITS-1:0]  chain_key  [MAX_ITEMS+1];
   logic [LEN_BITS-1:0]           chain_len  [MAX_ITEMS+1];
   logic [LEN_BITS-1:0]           chain_best [MAX_ITEMS+1];

   logic                          busy_ff;
   logic                          accept;
   logic                          dropped_ff, dropped_in;
   logic                          rsp_strobe_ff, rsp_strobe_in;
   logic [LENGTH_BITS-1:0]        rsp_length_ff, rsp_length_in;
   logic                          rsp_overflow_ff, rsp_overflow_in;
   logic [LEN_BITS-1:0]           tail_result;
   logic [WIDE_BITS-1:0]          tail_wide;
   lis_ctl_type                   tail_ctl;

   assign accept = start && !busy_ff;

   // A new beat enters the head of the chain searching, with a length of one.
   assign chain_ctl[0]  = '{valid: accept, active: 1'b1, last: req_last_item};
   assign chain_key[0]  = req_value;
   assign chain_len[0]  = LEN_BITS'(1);
   assign chain_best[0] = '0;

   // Each beat settles in the first empty cell it meets. Since beats keep their
   // order and spacing, the cell a beat settles in is always written before the
   // following beat arrives there, so every beat sees all earlier elements.
   for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
      lis_cell #(
         .VALUE_BITS (VALUE_BITS),
         .LEN_BITS   (LEN_BITS)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl_in   (chain_ctl[i]),
         .key_in   (chain_key[i]),
         .len_in   (chain_len[i]),
         .best_in  (chain_best[i]),
         .ctl_out  (chain_ctl[i+1]),
         .key_out  (chain_key[i+1]),
         .len_out  (chain_len[i+1]),
         .best_out (chain_best[i+1])
      );
   end

   assign tail_ctl = chain_ctl[MAX_ITEMS];

   // A beat still searching at the tail found every cell full and was dropped;
   // its own length then does not count toward the best.
   always_comb begin
      tail_result = chain_best[MAX_ITEMS];
      if (!tail_ctl.active && (chain_len[MAX_ITEMS] > tail_result)) begin
         tail_result = chain_len[MAX_ITEMS];
      end
   end

   assign tail_wide = WIDE_BITS'(tail_result);

   always_comb begin
      dropped_in      = dropped_ff;
      rsp_strobe_in   = 1'b0;
      rsp_length_in   = rsp_length_ff;
      rsp_overflow_in = rsp_overflow_ff;
      if (tail_ctl.valid) begin
         if (tail_ctl.last) begin
            rsp_strobe_in   = 1'b1;
            rsp_overflow_in = dropped_ff || tail_ctl.active;
            if (tail_wide > WIDE_BITS'(LENGTH_MAX)) begin
               rsp_length_in = LENGTH_MAX;
            end else begin
               rsp_length_in = tail_wide[LENGTH_BITS-1:0];
            end
            dropped_in = 1'b0;
         end else if (tail_ctl.active) begin
            dropped_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b1;
         dropped_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         busy_ff       <= 1'b0;
         dropped_ff    <= dropped_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      rsp_length_ff   <= rsp_length_in;
      rsp_overflow_ff <= rsp_overflow_in;
   end

   assign busy                   = busy_ff;
   assign rsp_strobe             = rsp_strobe_ff;
   assign rsp_subsequence_length = rsp_length_ff;
   assign rsp_overflow           = rsp_overflow_ff;

   // Every closing beat yields its result after a fixed trip down the chain.
   a_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_last_item) |-> ##(MAX_ITEMS + 1) rsp_strobe)
      else $error("closing beat did not produce a result on time");

   // A result always reports at least one element.
   a_length_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_subsequence_length != '0))
      else $error("result length is zero");

   // The overflow mark never leaks into the next sequence.
   a_dropped_cleared: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !dropped_ff)
      else $error("overflow mark survived the end of a sequence");

endmodule
